// ===== sv/modexp_pkg.sv =====
// shared constants for the modular exponentiation block
package modexp_pkg;

    // width of the data payload fields on the channels (bad_modulus is one bit)
    localparam int unsigned FIELD_WIDTH = 32;

    // default operand width, range 8 to FIELD_WIDTH
    localparam int unsigned OPERAND_WIDTH_DEF = 32;

endpackage

// ===== sv/modexp_req_if.sv =====
// request channel: base, exponent and modulus
interface modexp_req_if import modexp_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] base;
    logic [FIELD_WIDTH-1:0] exponent;
    logic [FIELD_WIDTH-1:0] modulus;

    modport source (output valid, output base, output exponent, output modulus, input ready);
    modport sink   (input valid, input base, input exponent, input modulus, output ready);

endinterface

// ===== sv/modexp_rsp_if.sv =====
// result channel: power_mod and bad_modulus flag
interface modexp_rsp_if import modexp_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] power_mod;
    logic                   bad_modulus;

    modport source (output valid, output power_mod, output bad_modulus, input ready);
    modport sink   (input valid, input power_mod, input bad_modulus, output ready);

endinterface

// ===== sv/modexp_mulmod.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module modexp_mulmod import modexp_pkg::*; #(
    parameter int unsigned W = OPERAND_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] p
);

    localparam int unsigned CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  m_reg, m_next;

    logic [W:0] m_ext;
    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] sum;
    logic [W:0] sum_red;

    // r = 2r mod m, then r = r + x*y_i mod m; x <= m keeps one subtract enough
    always_comb
    begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (y_reg[W-1] ? {1'b0, x_reg} : '0);
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            r_next    = '0;
            x_next    = x;
            y_next    = y;
            m_next    = m;
        end
        else if (busy_reg)
        begin
            r_next = sum_red[W-1:0];
            y_next = {y_reg[W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
        y_reg <= y_next;
        m_reg <= m_next;
    end

    assign done = done_reg;
    assign p    = r_reg;

endmodule

// ===== sv/modular_exponentiation.sv =====
// modular exponentiation top level: right-to-left square-and-multiply
//
//   channel  dir  payload                        request taken when
//   req      in   base, exponent, modulus        req.valid && req.ready
//   rsp      out  power_mod, bad_modulus         rsp.valid && rsp.ready
//
// one request at a time; every modular product goes through one shared
// bit-serial multiplier: S_START pulses its start, then it shifts through
// the multiplier bits while the sequencer waits in S_WAIT, and it raises done.
// a zero modulus skips the multiplier and finishes with the error flag set
// reset clears the control state only; no memory, no clearing pass
// req.ready stays high while idle, even when a result waits on a stalled rsp
module modular_exponentiation import modexp_pkg::*; #(
    parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    modexp_req_if.sink   req,
    modexp_rsp_if.source rsp
);

    localparam int unsigned W = OPERAND_WIDTH;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // product kinds run on the shared multiplier
    localparam logic [1:0] OP_RED = 2'd0;  // base mod m, as 1 * base
    localparam logic [1:0] OP_MUL = 2'd1;  // acc * sq
    localparam logic [1:0] OP_SQR = 2'd2;  // sq * sq

    logic [2:0]   state_reg, state_next;
    logic [1:0]   op_reg, op_next;
    logic [W-1:0] base_reg, base_next;
    logic [W-1:0] exp_reg, exp_next;
    logic [W-1:0] mod_reg, mod_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] sq_reg, sq_next;
    logic         bad_reg, bad_next;

    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_WIDTH-1:0] out_pow_reg, out_pow_next;
    logic                   out_bad_reg, out_bad_next;

    logic         req_take;
    logic         mm_start;
    logic [W-1:0] mm_x;
    logic [W-1:0] mm_y;
    logic         mm_done;
    logic [W-1:0] mm_p;

    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;

    // operand select for the shared multiplier; the multiplicand stays <= m
    always_comb
    begin
        mm_start = (state_reg == S_START);
        case (op_reg)
            OP_RED:
            begin
                mm_x = W'(1);
                mm_y = base_reg;
            end
            OP_MUL:
            begin
                mm_x = sq_reg;
                mm_y = acc_reg;
            end
            OP_SQR:
            begin
                mm_x = sq_reg;
                mm_y = sq_reg;
            end
            default:
            begin
                mm_x = '0;
                mm_y = '0;
            end
        endcase
    end

    modexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .m     (mod_reg),
        .done  (mm_done),
        .p     (mm_p)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_pow_next   = out_pow_reg;
        out_bad_next   = out_bad_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    // only the low operand bits take part
                    base_next = req.base[W-1:0];
                    exp_next  = req.exponent[W-1:0];
                    mod_next  = req.modulus[W-1:0];
                    acc_next  = W'(1);
                    op_next   = OP_RED;
                    if (req.modulus[W-1:0] == '0)
                    begin
                        // zero modulus: flag it, result forced to zero
                        bad_next   = 1'b1;
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mm_done)
                begin
                    case (op_reg)
                        OP_RED:
                        begin
                            sq_next    = mm_p;
                            state_next = S_STEP;
                        end
                        OP_MUL:
                        begin
                            acc_next = mm_p;
                            // square only when higher exponent bits remain
                            if (exp_reg[W-1:1] != '0)
                            begin
                                op_next    = OP_SQR;
                                state_next = S_START;
                            end
                            else
                            begin
                                exp_next   = exp_reg >> 1;
                                state_next = S_STEP;
                            end
                        end
                        default:
                        begin
                            sq_next    = mm_p;
                            exp_next   = exp_reg >> 1;
                            state_next = S_STEP;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                // one exponent bit per round, lsb first
                if (exp_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (exp_reg[0])
                begin
                    op_next    = OP_MUL;
                    state_next = S_START;
                end
                else
                begin
                    op_next    = OP_SQR;
                    state_next = S_START;
                end
            end
            S_FINISH:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pow_next   = FIELD_WIDTH'(acc_reg);
                    out_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_RED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        mod_reg     <= mod_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        bad_reg     <= bad_next;
        out_pow_reg <= out_pow_next;
        out_bad_reg <= out_bad_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.power_mod   = out_pow_reg;
    assign rsp.bad_modulus = out_bad_reg;

endmodule
